// ----- design/aesf_pkg.sv -----
// ----------------------------------------------------------------------------
// aesf_pkg
// Types and constants shared by the escape sequence filter core and its testbench.
// ----------------------------------------------------------------------------
package aesf_pkg;

  typedef struct packed {
    logic [7:0]  in_char;
    logic [15:0] cur_x;
    logic [15:0] cur_y;
  } aesf_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_char;
    logic [15:0] new_x;
    logic [15:0] new_y;
    logic [3:0]  fg_color;
    logic [3:0]  bg_color;
    logic        bold_on;
    logic        reverse_on;
    logic        last_item;
  } aesf_out_t;

  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_ABSORB = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [1:0] REG_DEFAULT_FG = 2'd0;
  localparam logic [1:0] REG_DEFAULT_BG = 2'd1;
  localparam logic [1:0] REG_CLEAR_CAP  = 2'd2;

  localparam logic [7:0] CH_ESC = 8'd27;
  localparam logic [7:0] CH_CSI = 8'h9b;
  localparam logic [7:0] CH_LBR = 8'h5b;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_M = 8'h6d;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_J = 8'h4a;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE2,
    ST_WALK,
    ST_REPLAY,
    ST_PASS,
    ST_DONE
  } aesf_state_e;

  // SGR decoder state: what the next byte means
  typedef enum logic [2:0] {
    SG_CODE,
    SG_AFTER0,
    SG_AFTER1,
    SG_AFTER2,
    SG_AFTER3,
    SG_AFTER4
  } aesf_sgr_e;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

endpackage

// ----- design/aesf_seq_mem.sv -----
// ----------------------------------------------------------------------------
// aesf_seq_mem
// Held byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module aesf_seq_mem #(
  parameter int Depth = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/ansi_escape_sequence_filter_core.sv -----
// ----------------------------------------------------------------------------
// ansi_escape_sequence_filter_core
// CSI escape sequence filter for a console byte stream.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries one console byte plus the cursor
// position the display holds. Each input yields one or more output
// transactions; last_item marks the final one. Bytes of an escape sequence
// are held in a small synchronous memory and answered with an absorbed
// result from ST_DONE (a CSI byte first passes ST_STORE2 to store its '[').
// A completed sequence is evaluated by walking the held bytes after ESC '['
// through the memory read port, one byte per cycle; the result is loaded
// once the walk ends and the output register is free. An aborted sequence
// replays every held byte, one per cycle while the receiver takes them,
// then passes the byte. Plain bytes are passed through as a single result.
// One input is worked on at a time; the input ready is low until the last
// result is handed to the output register. The output register holds its
// transaction while out_ready_i is low, and the sequencer waits on it; a
// stall during replay makes the sequencer reread the held byte. Reset
// empties the held sequence and restores the default attributes; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module ansi_escape_sequence_filter_core
  import aesf_pkg::*;
#(
  parameter int MAX_SEQ = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [3:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  aesf_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output aesf_out_t out_data_o
);

  localparam int AW = $clog2(MAX_SEQ);
  localparam int CW = $clog2(MAX_SEQ + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_SEQ);

  // configuration
  logic [3:0] def_fg_q, def_bg_q;
  logic       clr_cap_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_fg_q  <= 4'd7;
      def_bg_q  <= 4'd0;
      clr_cap_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DEFAULT_FG: def_fg_q  <= cfg_data_i;
        REG_DEFAULT_BG: def_bg_q  <= cfg_data_i;
        REG_CLEAR_CAP:  clr_cap_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  aesf_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0] last_q, last_d;      // last held byte
  logic [3:0] fg_q, fg_d, bg_q, bg_d;
  logic bold_q, bold_d, rev_q, rev_d;
  logic [7:0] c_q, c_d;
  logic [15:0] x_q, x_d, y_q, y_d;
  logic [CW-1:0] idx_q, idx_d;     // walk/replay read position
  logic rv_q, rv_d;                // read data valid for byte idx_q-1
  logic [16:0] p_q, p_d;
  logic numon_q, numon_d;
  aesf_sgr_e sg_q, sg_d;
  logic [7:0] prev_q, prev_d;
  logic ov_q, ov_d;
  aesf_out_t ov_data_q, ov_data_d;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  aesf_seq_mem #(.Depth(MAX_SEQ), .AW(AW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign raddr = idx_q[AW-1:0];
  logic out_free;
  assign out_free   = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = ov_data_q;

  function automatic aesf_out_t mk(input logic [1:0] k, input logic [7:0] ch,
                                   input logic [15:0] x, input logic [15:0] y,
                                   input logic [3:0] f, input logic [3:0] b,
                                   input logic bo, input logic rv, input logic l);
    aesf_out_t o;
    o.kind = k; o.out_char = ch; o.new_x = x; o.new_y = y;
    o.fg_color = f; o.bg_color = b; o.bold_on = bo; o.reverse_on = rv;
    o.last_item = l;
    return o;
  endfunction

  logic [16:0] p1, sum;
  logic [20:0] mul;
  logic        full, fin;
  logic [7:0]  ci;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; last_d = last_q;
    fg_d = fg_q; bg_d = bg_q; bold_d = bold_q; rev_d = rev_q;
    c_d = c_q; x_d = x_q; y_d = y_q; idx_d = idx_q; rv_d = 1'b0;
    p_d = p_q; numon_d = numon_q; sg_d = sg_q; prev_d = prev_q;
    ov_d = ov_q && !out_ready_i; ov_data_d = ov_data_q;
    we = 1'b0; waddr = cnt_q[AW-1:0]; wdata = 8'd0;
    p1 = 17'd0; sum = 17'd0; mul = 21'd0;
    ci = in_data_i.in_char;
    full = (cnt_q == MaxCnt);
    fin = (ci == CH_M) || (ci == CH_A) || (ci == CH_B) || (ci == CH_C) ||
          (ci == CH_D) || (ci == CH_H) || (ci == CH_J);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          c_d = ci; x_d = in_data_i.cur_x; y_d = in_data_i.cur_y;
          idx_d = '0; rv_d = 1'b0;
          if (cnt_q == '0) begin
            if (ci == CH_ESC) begin
              we = 1'b1; wdata = CH_ESC; cnt_d = cnt_q + 1'b1; last_d = CH_ESC;
              state_d = ST_DONE;
            end else if (ci == CH_CSI) begin
              we = 1'b1; wdata = CH_ESC; cnt_d = cnt_q + 1'b1;
              state_d = ST_STORE2;
            end else begin
              state_d = ST_PASS;
            end
          end else if (last_q == CH_ESC) begin
            if (ci == CH_LBR && !full) begin
              we = 1'b1; wdata = ci; cnt_d = cnt_q + 1'b1; last_d = ci;
              state_d = ST_DONE;
            end else begin
              state_d = ST_REPLAY;
            end
          end else if ((is_digit(ci) || ci == CH_SEMI) && !full) begin
            we = 1'b1; wdata = ci; cnt_d = cnt_q + 1'b1; last_d = ci;
            state_d = ST_DONE;
          end else if (fin && !full) begin
            // complete: walk held bytes from index 2
            idx_d = CW'(2); p_d = '0; numon_d = 1'b1; sg_d = SG_CODE;
            prev_d = 8'd0; state_d = ST_WALK;
          end else begin
            state_d = ST_REPLAY;
          end
        end
      end
      ST_STORE2: begin
        we = 1'b1; wdata = CH_LBR; cnt_d = cnt_q + 1'b1; last_d = CH_LBR;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          ov_d = 1'b1;
          ov_data_d = mk(KIND_ABSORB, 8'd0, x_q, y_q, fg_q, bg_q, bold_q, rev_q, 1'b1);
          state_d = ST_IDLE;
        end
      end
      ST_WALK: begin
        // one held byte per cycle: rdata is byte idx_q-1 when rv_q
        if (idx_q < cnt_q) begin
          idx_d = idx_q + 1'b1; rv_d = 1'b1;
        end
        if (rv_q) begin
          // leading number
          if (numon_q) begin
            if (is_digit(rdata)) begin
              mul = {2'b0, p_q[15:0], 3'b0} + {4'b0, p_q[15:0], 1'b0};
              if (p_q[16] || mul > 21'hffff) p_d = 17'hffff;
              else begin
                sum = mul[16:0] + {9'd0, rdata - CH_0};
                p_d = (sum > 17'hffff) ? 17'hffff : sum;
              end
            end else numon_d = 1'b0;
          end
          // SGR decode, follows the byte pairing of the walk
          if (c_q == CH_M) begin
            prev_d = rdata;
            case (sg_q)
              SG_CODE: begin
                if (!(rdata == CH_M || (is_digit(rdata) && is_digit(prev_q)))) begin
                  if (rdata == 8'h30) begin
                    fg_d = def_fg_q; bg_d = def_bg_q; sg_d = SG_AFTER0;
                  end else if (rdata == 8'h31) begin
                    bold_d = 1'b1; sg_d = SG_AFTER1;
                  end else if (rdata == 8'h32) sg_d = SG_AFTER2;
                  else if (rdata == 8'h33) sg_d = SG_AFTER3;
                  else if (rdata == 8'h34) sg_d = SG_AFTER4;
                  else if (rdata == 8'h37) rev_d = 1'b1;
                end
              end
              SG_AFTER2: begin
                if (rdata == 8'h37) rev_d = 1'b0;
                sg_d = SG_CODE;
              end
              SG_AFTER3: begin
                if (rdata >= CH_0 && rdata <= 8'h37) fg_d = rdata[3:0];
                else if (rdata == 8'h38 || rdata == CH_9) fg_d = def_fg_q;
                sg_d = SG_CODE;
              end
              SG_AFTER4: begin
                if (rdata >= CH_0 && rdata <= 8'h37) bg_d = rdata[3:0];
                else if (rdata == CH_9) bg_d = def_bg_q;
                sg_d = SG_CODE;
              end
              default: sg_d = SG_CODE;
            endcase
          end
        end
        if (!rv_q && idx_q >= cnt_q) begin
          // walk finished
          p1 = (p_q == '0) ? 17'd1 : p_q;
          if (out_free) begin
            ov_d = 1'b1;
            ov_data_d = mk(KIND_ABSORB, 8'd0, x_q, y_q, fg_q, bg_q, bold_q, rev_q, 1'b1);
            case (c_q)
              CH_A: ov_data_d.new_y = (y_q > p1[15:0] && !p1[16]) ?
                                      y_q - p1[15:0] : 16'd0;
              CH_B: begin
                sum = {1'b0, y_q} + p1;
                ov_data_d.new_y = sum[16] ? 16'hffff : sum[15:0];
              end
              CH_C: begin
                sum = {1'b0, x_q} + p1;
                ov_data_d.new_x = sum[16] ? 16'hffff : sum[15:0];
              end
              CH_D: ov_data_d.new_x = (x_q > p1[15:0] && !p1[16]) ?
                                      x_q - p1[15:0] : 16'd0;
              CH_H: begin
                ov_data_d.new_x = 16'd0; ov_data_d.new_y = 16'd0;
              end
              CH_J: if (clr_cap_q) ov_data_d.kind = KIND_CLEAR;
              default: ;
            endcase
            cnt_d = '0; state_d = ST_IDLE;
          end else begin
            idx_d = idx_q;
          end
        end
      end
      ST_REPLAY: begin
        // idx_q: next address to read; rv_q: rdata holds byte idx_q-1
        if (rv_q) begin
          if (out_free) begin
            ov_d = 1'b1;
            ov_data_d = mk(KIND_CHAR, rdata, x_q, y_q, fg_q, bg_q, bold_q, rev_q, 1'b0);
            if (idx_q < cnt_q) begin
              idx_d = idx_q + 1'b1; rv_d = 1'b1;
            end else state_d = ST_PASS;
          end else begin
            idx_d = idx_q - 1'b1;   // reread the held byte
          end
        end else begin
          idx_d = idx_q + 1'b1; rv_d = 1'b1;
        end
      end
      ST_PASS: begin
        if (out_free) begin
          ov_d = 1'b1;
          ov_data_d = mk(KIND_CHAR, c_q, x_q, y_q, fg_q, bg_q, bold_q, rev_q, 1'b1);
          cnt_d = '0; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cnt_q <= '0; last_q <= 8'd0;
      fg_q <= 4'd7; bg_q <= 4'd0; bold_q <= 1'b0; rev_q <= 1'b0;
      idx_q <= '0; rv_q <= 1'b0; numon_q <= 1'b0; sg_q <= SG_CODE;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; last_q <= last_d;
      fg_q <= fg_d; bg_q <= bg_d; bold_q <= bold_d; rev_q <= rev_d;
      idx_q <= idx_d; rv_q <= rv_d; numon_q <= numon_d; sg_q <= sg_d;
      ov_q <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    c_q <= c_d; x_q <= x_d; y_q <= y_d; p_q <= p_d; prev_q <= prev_d;
    ov_data_q <= ov_data_d;
  end

endmodule

// ----- sim/ansi_escape_sequence_filter_core_test.sv -----
// ----------------------------------------------------------------------------
// ansi_escape_sequence_filter_core_test
// Self-checking testbench for the CSI escape sequence filter. A driver sends
// console bytes from a queue, and a predictor written against the filter's
// rules computes the expected results. A monitor compares every output
// transaction with the oldest expected one. Random gaps on both sides and
// several register settings are used.
// ----------------------------------------------------------------------------
module ansi_escape_sequence_filter_core_test;
  import aesf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEQ_DEPTH   = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [3:0] cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  aesf_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  aesf_out_t out_data_o;

  ansi_escape_sequence_filter_core #(.MAX_SEQ(SEQ_DEPTH)) dut (.*);

  always #6 clk_i = ~clk_i;

  // Predictor state
  logic [7:0] held_seq [SEQ_DEPTH];
  int         held_len = 0;
  logic [3:0] attr_fg = 4'd7, attr_bg = 4'd0;
  logic       attr_bold = 1'b0, attr_rev = 1'b0;
  logic [3:0] dflt_fg = 4'd7, dflt_bg = 4'd0;
  logic       can_clear = 1'b1;

  aesf_in_t  byte_queue [$];
  aesf_out_t expected_results [$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        hold_off = 1'b0;
  bit        in_fire = 1'b0;

  function automatic bit digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic [7:0] held_at(int i);
    return (i < held_len) ? held_seq[i] : 8'd0;
  endfunction

  function automatic bit push_held(logic [7:0] c);
    if (held_len >= SEQ_DEPTH) return 1'b0;
    held_seq[held_len] = c;
    held_len++;
    return 1'b1;
  endfunction

  function automatic void add_result(logic [1:0] k, logic [7:0] ch, logic [15:0] x,
                                     logic [15:0] y, logic last);
    aesf_out_t r;
    r.kind = k; r.out_char = ch; r.new_x = x; r.new_y = y;
    r.fg_color = attr_fg; r.bg_color = attr_bg;
    r.bold_on = attr_bold; r.reverse_on = attr_rev; r.last_item = last;
    expected_results.push_back(r);
  endfunction

  // Walk the held SGR bytes, pairing a code digit with the byte after it
  function automatic void apply_sgr();
    int i;
    logic [7:0] c, prev;
    i = 2; c = 8'd0;
    while (i < held_len) begin
      prev = c;
      c = held_at(i); i++;
      if (c == CH_M || (digit(c) && digit(prev))) continue;
      case (c)
        "0": begin c = held_at(i); i++; attr_fg = dflt_fg; attr_bg = dflt_bg; end
        "1": begin c = held_at(i); i++; attr_bold = 1'b1; end
        "2": begin c = held_at(i); i++; if (c == "7") attr_rev = 1'b0; end
        "3": begin
          c = held_at(i); i++;
          if (c >= "0" && c <= "7") attr_fg = 4'(c - "0");
          else if (c == "8" || c == "9") attr_fg = dflt_fg;
        end
        "4": begin
          c = held_at(i); i++;
          if (c >= "0" && c <= "7") attr_bg = 4'(c - "0");
          else if (c == "9") attr_bg = dflt_bg;
        end
        "7": attr_rev = 1'b1;
        default: ;
      endcase
    end
  endfunction

  function automatic void predict_filter(aesf_in_t t);
    logic [7:0] c;
    int x, y, p;
    bit drop, done;
    logic [1:0] k;
    c = t.in_char; x = int'(t.cur_x); y = int'(t.cur_y); drop = 0; done = 0;
    if (held_len == 0) begin
      if (c == CH_ESC) drop = !push_held(c);
      else if (c == CH_CSI) begin
        void'(push_held(CH_ESC)); void'(push_held(CH_LBR));
      end else drop = 1;
    end else if (held_at(held_len - 1) == CH_ESC) begin
      drop = (c == CH_LBR) ? !push_held(c) : 1'b1;
    end else if (digit(c) || c == CH_SEMI) begin
      drop = !push_held(c);
    end else if (c inside {CH_M, CH_A, CH_B, CH_C, CH_D, CH_H, CH_J}) begin
      if (push_held(c)) done = 1; else drop = 1;
    end else drop = 1;

    if (done) begin
      k = KIND_ABSORB; p = 0;
      for (int i = 2; i < held_len && digit(held_at(i)); i++) begin
        p = p * 10 + int'(held_at(i) - CH_0);
        if (p > 65535) p = 65535;
      end
      if (p == 0) p = 1;
      case (c)
        CH_M: apply_sgr();
        CH_A: y = (y > p) ? y - p : 0;
        CH_B: y = (y + p > 65535) ? 65535 : y + p;
        CH_C: x = (x + p > 65535) ? 65535 : x + p;
        CH_D: x = (x > p) ? x - p : 0;
        CH_H: begin x = 0; y = 0; end
        default: if (can_clear) k = KIND_CLEAR;
      endcase
      held_len = 0;
      add_result(k, 8'd0, 16'(x), 16'(y), 1'b1);
    end else if (!drop) begin
      add_result(KIND_ABSORB, 8'd0, 16'(x), 16'(y), 1'b1);
    end else begin
      // Replay held bytes, then pass the byte through
      for (int i = 0; i < held_len; i++)
        add_result(KIND_CHAR, held_seq[i], 16'(x), 16'(y), 1'b0);
      held_len = 0;
      add_result(KIND_CHAR, c, 16'(x), 16'(y), 1'b1);
    end
  endfunction

  function automatic void queue_byte(logic [7:0] c);
    aesf_in_t t;
    t.in_char = c;
    case ($urandom_range(0, 5))
      0: begin t.cur_x = 16'hffff; t.cur_y = 16'hffff; end
      1: begin t.cur_x = 16'h0; t.cur_y = 16'h0; end
      default: begin t.cur_x = 16'($urandom); t.cur_y = 16'($urandom); end
    endcase
    byte_queue.push_back(t);
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  function automatic logic [7:0] random_final();
    logic [7:0] f [7] = '{CH_M, CH_A, CH_B, CH_C, CH_D, CH_H, CH_J};
    return f[$urandom_range(0, 6)];
  endfunction

  // Well-formed sequence with random body, sometimes broken or overlong
  function automatic void queue_random_sequence();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 5);
    if ($urandom_range(0, 1)) queue_byte(CH_CSI);
    else begin queue_byte(CH_ESC); queue_byte(CH_LBR); end
    for (int i = 0; i < n; i++)
      queue_byte(($urandom_range(0, 4) == 0) ? CH_SEMI : 8'(CH_0 + $urandom_range(0, 9)));
    case ($urandom_range(0, 9))
      0: queue_byte(8'($urandom));
      default: queue_byte(random_final());
    endcase
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_DEFAULT_FG: dflt_fg = val;
      REG_DEFAULT_BG: dflt_bg = val;
      default: can_clear = val[0];
    endcase
  endtask

  task automatic drain();
    while (byte_queue.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  // Driver: present queued bytes with random gaps
  int gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        if (gap == 0 && !hold_off && byte_queue.size() != 0) begin
          in_data_i <= byte_queue.pop_front();
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        end else in_valid_i <= 1'b0;
      end else if (!in_valid_i) begin
        if (gap > 0) gap--;
        else if (!hold_off && byte_queue.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= byte_queue.pop_front();
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        end
      end
    end
  end

  // Drive the receiver ready with random stalls, mostly short, a few long
  int stall = 0;
  always @(negedge clk_i) begin
    if (stall > 0) begin
      out_ready_i <= 1'b0;
      stall--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      stall = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    end else out_ready_i <= 1'b1;
  end

  // Monitor: predict on accepted input, check accepted output
  always @(posedge clk_i) begin
    cycles++;
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (in_fire) predict_filter(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %p", out_data_o);
      end else begin
        aesf_out_t e;
        e = expected_results.pop_front();
        if (e !== out_data_o) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_data_o);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_reg(REG_DEFAULT_FG, 4'd7);
    write_reg(REG_DEFAULT_BG, 4'd0);
    write_reg(REG_CLEAR_CAP, 4'd1);

    // Directed: cursor moves, home, clear, SGR codes, aborts, overflow
    queue_text("\033[A\033[0B\033[65535C\033[99999D\033[H\033[J");
    queue_text("\033[0;1;31;44;7m\033[27;39;49m\033[38;48;25m");
    queue_byte(CH_CSI); queue_text("3A");
    queue_byte(8'h00); queue_byte(8'hff);
    queue_text("\033x\033[12q\033[1234567890123456m");
    drain();

    // Extreme settings, no clear support
    write_reg(REG_DEFAULT_FG, 4'hf);
    write_reg(REG_DEFAULT_BG, 4'hf);
    write_reg(REG_CLEAR_CAP, 4'd0);
    queue_text("\033[J\033[0m\033[39;49m");
    for (int i = 0; i < 2; i++) queue_random_sequence();
    // Hold the sender midway until everything has come out
    while (byte_queue.size() > 6) @(posedge clk_i);
    hold_off = 1'b1;
    do @(posedge clk_i); while (in_valid_i || expected_results.size() != 0);
    hold_off = 1'b0;
    drain();

    write_reg(REG_DEFAULT_FG, 4'h0);
    write_reg(REG_DEFAULT_BG, 4'h5);
    write_reg(REG_CLEAR_CAP, 4'd1);
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 3) == 0) queue_byte(8'($urandom));
      else queue_random_sequence();
    end
    drain();

    if (mismatches == 0 && expected_results.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
